// ===== rtl/fpkc_pkg.sv =====
// Package with the item types, status codes and helpers of the fire pulse keep-alive controller.
package fpkc_pkg;

  typedef struct packed {
    logic        msg_present;
    logic        msg_ok;
    logic [2:0]  msg_status;
    logic [7:0]  msg_index;
    logic [7:0]  msg_fire_value;
    logic [7:0]  msg_drive_left;
    logic [7:0]  msg_drive_right;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status_out;
    logic       solenoid_open;
    logic [7:0] left_drive;
    logic [7:0] right_drive;
  } out_item_t;

  localparam logic [2:0] ST_DISABLED  = 3'd0;
  localparam logic [2:0] ST_ENABLED   = 3'd1;
  localparam logic [2:0] ST_ADJUSTING = 3'd2;
  localparam logic [2:0] ST_PRIMED    = 3'd3;
  localparam logic [2:0] ST_FIRING    = 3'd4;

  localparam logic [1:0] REG_KEEPALIVE  = 2'd0;
  localparam logic [1:0] REG_MIN_PULSE  = 2'd1;
  localparam logic [1:0] REG_PULSE_STEP = 2'd2;
  localparam logic [1:0] REG_MAX_FIRE   = 2'd3;

  localparam logic [15:0] KEEPALIVE_RST  = 16'd1000;
  localparam logic [9:0]  MIN_PULSE_RST  = 10'd100;
  localparam logic [6:0]  PULSE_STEP_RST = 7'd10;
  localparam logic [7:0]  MAX_FIRE_RST   = 8'd20;
  localparam logic [15:0] PULSE_LEN_RST  = 16'd100;

  localparam logic [7:0]  NEUTRAL        = 8'd90;
  localparam logic [13:0] RECIP_7        = 14'd9363;

  // Speed s maps to 90 +/- s*90/63; s*90/63 equals s*10/7, done by a reciprocal multiply.
  function automatic logic [7:0] drive_map(input logic [7:0] b);
    logic [9:0]  x;
    logic [23:0] p;
    logic [7:0]  m;
    x = {4'd0, b[5:0]} * 10'd10;
    p = {14'd0, x} * {10'd0, RECIP_7};
    m = p[23:16];
    drive_map = b[6] ? (NEUTRAL - m) : (NEUTRAL + m);
  endfunction

endpackage

// ===== rtl/fire_pulse_keepalive_controller.sv =====
// Fire pulse keep-alive controller: one tick item in, one result item out.
// An accepted item is held in the input register; its result then moves into the result register.
// Throughput: one item per cycle while out_stall is low; the single pass between the two registers sets this rate.
// The output register lets a new item be taken while a finished result waits.
// Reset (rst_n low, synchronous) clears the controller state, the pipeline valids and
// loads the configuration registers with their defaults.
module fire_pulse_keepalive_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fpkc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fpkc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);

  logic [15:0] keepalive_r;
  logic [9:0]  min_pulse_r;
  logic [6:0]  pulse_step_r;
  logic [7:0]  max_fire_r;

  logic [2:0]  cur_status_r, cur_status_nxt;
  logic [7:0]  cmd_index_r, cmd_index_nxt;
  logic [7:0]  cmd_fire_r, cmd_fire_nxt;
  logic [7:0]  cmd_left_r, cmd_left_nxt;
  logic [7:0]  cmd_right_r, cmd_right_nxt;
  logic [7:0]  seen_index_r, seen_index_nxt;
  logic        seen_valid_r, seen_valid_nxt;
  logic [31:0] seen_time_r, seen_time_nxt;
  logic [15:0] pulse_len_r, pulse_len_nxt;
  logic        pulse_active_r, pulse_active_nxt;
  logic        fire_latched_r, fire_latched_nxt;
  logic [31:0] pulse_end_r, pulse_end_nxt;

  logic                s1_valid_r;
  fpkc_pkg::in_item_t  s1_data_r;
  logic                out_valid_r;
  fpkc_pkg::out_item_t out_data_r, out_data_nxt;

  logic        s1_adv;
  logic        in_take;
  logic [31:0] now;
  logic [2:0]  st;
  logic        pulse_running;
  logic        seen_upd;
  logic [31:0] seen_time_eff;
  logic [31:0] age;
  logic [15:0] fire_prod;
  logic [15:0] pulse_calc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keepalive_r  <= fpkc_pkg::KEEPALIVE_RST;
      min_pulse_r  <= fpkc_pkg::MIN_PULSE_RST;
      pulse_step_r <= fpkc_pkg::PULSE_STEP_RST;
      max_fire_r   <= fpkc_pkg::MAX_FIRE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpkc_pkg::REG_KEEPALIVE:  keepalive_r  <= cfg_wdata;
        fpkc_pkg::REG_MIN_PULSE:  min_pulse_r  <= cfg_wdata[9:0];
        fpkc_pkg::REG_PULSE_STEP: pulse_step_r <= cfg_wdata[6:0];
        fpkc_pkg::REG_MAX_FIRE:   max_fire_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    now            = s1_data_r.now_ms;
    cur_status_nxt = cur_status_r;
    cmd_index_nxt  = cmd_index_r;
    cmd_fire_nxt   = cmd_fire_r;
    cmd_left_nxt   = cmd_left_r;
    cmd_right_nxt  = cmd_right_r;
    seen_index_nxt = seen_index_r;
    seen_valid_nxt = seen_valid_r;
    seen_time_nxt  = seen_time_r;
    pulse_end_nxt  = pulse_end_r;

    if (s1_data_r.msg_present) begin
      if (s1_data_r.msg_ok) begin
        cur_status_nxt = s1_data_r.msg_status;
        cmd_index_nxt  = s1_data_r.msg_index;
        cmd_fire_nxt   = s1_data_r.msg_fire_value;
        cmd_left_nxt   = s1_data_r.msg_drive_left;
        cmd_right_nxt  = s1_data_r.msg_drive_right;
      end else begin
        cur_status_nxt = fpkc_pkg::ST_DISABLED;
      end
    end

    st            = cur_status_nxt;
    pulse_running = pulse_active_r && (now < pulse_end_r);
    seen_upd      = !seen_valid_r || (seen_index_r != cmd_index_nxt);
    seen_time_eff = seen_upd ? now : seen_time_r;
    age           = now - seen_time_eff;

    if (cur_status_nxt != fpkc_pkg::ST_DISABLED) begin
      if (pulse_running) begin
        st = fpkc_pkg::ST_ADJUSTING;
      end
      if (seen_upd) begin
        seen_index_nxt = cmd_index_nxt;
        seen_valid_nxt = 1'b1;
        seen_time_nxt  = now;
      end
      if (age > {16'd0, keepalive_r}) begin
        st = fpkc_pkg::ST_DISABLED;
      end
    end

    fire_prod     = {8'd0, cmd_fire_nxt} * {9'd0, pulse_step_r};
    pulse_calc    = {6'd0, min_pulse_r} + fire_prod;
    pulse_len_nxt = (cmd_fire_nxt <= max_fire_r) ? pulse_calc : pulse_len_r;

    pulse_active_nxt = pulse_running;
    fire_latched_nxt = fire_latched_r;
    if (st != fpkc_pkg::ST_FIRING && st != fpkc_pkg::ST_ADJUSTING) begin
      pulse_active_nxt = 1'b0;
      fire_latched_nxt = 1'b0;
    end

    out_data_nxt.left_drive  = fpkc_pkg::NEUTRAL;
    out_data_nxt.right_drive = fpkc_pkg::NEUTRAL;
    if (st == fpkc_pkg::ST_ENABLED) begin
      out_data_nxt.left_drive  = fpkc_pkg::drive_map(cmd_left_nxt);
      out_data_nxt.right_drive = fpkc_pkg::drive_map(cmd_right_nxt);
    end

    if (st == fpkc_pkg::ST_FIRING && !fire_latched_nxt) begin
      pulse_active_nxt = 1'b1;
      fire_latched_nxt = 1'b1;
      pulse_end_nxt    = now + {16'd0, pulse_len_nxt};
      st               = fpkc_pkg::ST_ADJUSTING;
    end

    out_data_nxt.status_out    = st;
    out_data_nxt.solenoid_open = pulse_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_status_r   <= fpkc_pkg::ST_DISABLED;
      cmd_index_r    <= 8'd0;
      cmd_fire_r     <= 8'd0;
      cmd_left_r     <= 8'd0;
      cmd_right_r    <= 8'd0;
      seen_index_r   <= 8'd0;
      seen_valid_r   <= 1'b0;
      seen_time_r    <= 32'd0;
      pulse_len_r    <= fpkc_pkg::PULSE_LEN_RST;
      pulse_active_r <= 1'b0;
      fire_latched_r <= 1'b0;
      pulse_end_r    <= 32'd0;
    end else if (s1_adv) begin
      cur_status_r   <= out_data_nxt.status_out;
      cmd_index_r    <= cmd_index_nxt;
      cmd_fire_r     <= cmd_fire_nxt;
      cmd_left_r     <= cmd_left_nxt;
      cmd_right_r    <= cmd_right_nxt;
      seen_index_r   <= seen_index_nxt;
      seen_valid_r   <= seen_valid_nxt;
      seen_time_r    <= seen_time_nxt;
      pulse_len_r    <= pulse_len_nxt;
      pulse_active_r <= pulse_active_nxt;
      fire_latched_r <= fire_latched_nxt;
      pulse_end_r    <= pulse_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An open pulse always carries a set fire latch.
  a_pulse_latched: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_active_r |-> fire_latched_r)
    else $error("pulse active without fire latch");

  // The solenoid is open only while adjusting or firing.
  a_open_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.solenoid_open) |->
    (out_data_r.status_out == fpkc_pkg::ST_ADJUSTING ||
     out_data_r.status_out == fpkc_pkg::ST_FIRING))
    else $error("solenoid open in a status that does not allow it");

  // Drives leave neutral only when enabled.
  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status_out != fpkc_pkg::ST_ENABLED) |->
    (out_data_r.left_drive == fpkc_pkg::NEUTRAL &&
     out_data_r.right_drive == fpkc_pkg::NEUTRAL))
    else $error("drive not neutral outside enabled");

  // A result that advances out of the pass leaves a valid result register behind.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result lost after advance");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the fire pulse keep-alive controller.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  fpkc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fpkc_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = fpkc_pkg::REG_KEEPALIVE;
  logic [15:0]         cfg_wdata = '0;

  fire_pulse_keepalive_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Controller state as the checker sees it.
  logic [15:0] ka_limit = fpkc_pkg::KEEPALIVE_RST;
  logic [9:0]  base_open = fpkc_pkg::MIN_PULSE_RST;
  logic [6:0]  open_step = fpkc_pkg::PULSE_STEP_RST;
  logic [7:0]  fire_cap = fpkc_pkg::MAX_FIRE_RST;
  logic [2:0]  mode_q = fpkc_pkg::ST_DISABLED;
  logic [7:0]  cmd_idx = '0;
  logic [7:0]  cmd_fire = '0;
  logic [7:0]  cmd_l = '0;
  logic [7:0]  cmd_r = '0;
  logic [7:0]  last_idx = '0;
  logic        last_idx_ok = 1'b0;
  logic [31:0] last_idx_ms = '0;
  logic [15:0] open_len = fpkc_pkg::PULSE_LEN_RST;
  logic        pulse_on = 1'b0;
  logic        shot_done = 1'b0;
  logic [31:0] close_ms = '0;

  fpkc_pkg::in_item_t  pending_ticks[$];
  fpkc_pkg::out_item_t outcome_q[$];
  fpkc_pkg::out_item_t want;
  logic        in_took = 1'b0;
  logic        hold_on = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned phase_sel = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned ticks_made = 0;
  logic [31:0] clock_ms = '0;
  logic [7:0]  idx_ctr = '0;

  function automatic logic [7:0] speed_cmd(logic [7:0] b);
    int unsigned mag;
    mag = 32'(b[5:0]);
    mag = mag * 90 / 63;
    return b[6] ? fpkc_pkg::NEUTRAL - 8'(mag) : fpkc_pkg::NEUTRAL + 8'(mag);
  endfunction

  function automatic fpkc_pkg::out_item_t advance_controller(fpkc_pkg::in_item_t t);
    logic [2:0]          st;
    fpkc_pkg::out_item_t o;
    o.left_drive = fpkc_pkg::NEUTRAL;
    o.right_drive = fpkc_pkg::NEUTRAL;
    if (t.msg_present) begin
      if (t.msg_ok) begin
        mode_q = t.msg_status;
        cmd_idx = t.msg_index;
        cmd_fire = t.msg_fire_value;
        cmd_l = t.msg_drive_left;
        cmd_r = t.msg_drive_right;
      end else begin
        mode_q = fpkc_pkg::ST_DISABLED;
      end
    end
    if (mode_q != fpkc_pkg::ST_DISABLED) begin
      if (pulse_on && t.now_ms < close_ms) mode_q = fpkc_pkg::ST_ADJUSTING;
      if (!last_idx_ok || last_idx != cmd_idx) begin
        last_idx = cmd_idx;
        last_idx_ok = 1'b1;
        last_idx_ms = t.now_ms;
      end
      if (32'(t.now_ms - last_idx_ms) > {16'd0, ka_limit}) mode_q = fpkc_pkg::ST_DISABLED;
    end
    st = mode_q;
    if (cmd_fire <= fire_cap) open_len = 16'(32'(base_open) + 32'(cmd_fire) * 32'(open_step));
    if (pulse_on && t.now_ms >= close_ms) pulse_on = 1'b0;
    if (st != fpkc_pkg::ST_FIRING && st != fpkc_pkg::ST_ADJUSTING) begin
      pulse_on = 1'b0;
      shot_done = 1'b0;
    end
    if (st == fpkc_pkg::ST_ENABLED) begin
      o.left_drive = speed_cmd(cmd_l);
      o.right_drive = speed_cmd(cmd_r);
    end
    if (st == fpkc_pkg::ST_FIRING && !shot_done) begin
      pulse_on = 1'b1;
      shot_done = 1'b1;
      close_ms = t.now_ms + {16'd0, open_len};
      st = fpkc_pkg::ST_ADJUSTING;
    end
    mode_q = st;
    o.status_out = st;
    o.solenoid_open = pulse_on;
    return o;
  endfunction

  // Sender: a new tick is offered only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_ticks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) outcome_q.push_back(advance_controller(in_data));
  end

  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected result: %p", out_data);
        fail_cnt++;
      end else begin
        want = outcome_q.pop_front();
        if (out_data.status_out !== want.status_out ||
            out_data.solenoid_open !== want.solenoid_open ||
            out_data.left_drive !== want.left_drive ||
            out_data.right_drive !== want.right_drive) begin
          if (fail_cnt < 10)
            $display("mismatch: status %0d/%0d solenoid %0d/%0d left %0d/%0d right %0d/%0d",
                     want.status_out, out_data.status_out, want.solenoid_open,
                     out_data.solenoid_open, want.left_drive, out_data.left_drive,
                     want.right_drive, out_data.right_drive);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("fire_pulse_keepalive_controller test failed");
      $finish;
    end
  end

  // The long receiver hold-off fills the block while the sender keeps offering ticks.
  initial begin
    wait (phase_sel == 3);
    repeat (20) @(posedge clk);
    hold_on = 1'b1;
    repeat (80) @(posedge clk);
    hold_on = 1'b0;
  end

  task automatic add_tick(bit p, bit ok, logic [2:0] st, logic [7:0] idx, logic [7:0] fire,
                          logic [7:0] dl, logic [7:0] dr, logic [31:0] now);
    fpkc_pkg::in_item_t t;
    t.msg_present = p;
    t.msg_ok = ok;
    t.msg_status = st;
    t.msg_index = idx;
    t.msg_fire_value = fire;
    t.msg_drive_left = dl;
    t.msg_drive_right = dr;
    t.now_ms = now;
    pending_ticks.push_back(t);
    ticks_made++;
  endtask

  function automatic bit rand_bit();
    return 1'($urandom());
  endfunction

  function automatic logic [2:0] rand_st();
    return 3'($urandom());
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom());
  endfunction

  function automatic logic [31:0] step_clock();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) clock_ms += 32'($urandom_range(0, 120));
    else if (r < 93) clock_ms += 32'($urandom_range(100, 1500));
    else if (r < 97) clock_ms = $urandom();
    else clock_ms -= 32'($urandom_range(1, 400));
    return clock_ms;
  endfunction

  function automatic logic [7:0] fresh_idx();
    if ($urandom_range(9) != 0) idx_ctr = idx_ctr + 8'd1;
    return idx_ctr;
  endfunction

  function automatic logic [7:0] pick_fire();
    int unsigned top;
    top = (fire_cap < 8'd250) ? 32'(fire_cap) + 32'd3 : 32'd255;
    if ($urandom_range(99) < 70) return 8'($urandom_range(0, top));
    return rand_byte();
  endfunction

  task automatic add_random(int unsigned n);
    int unsigned goal, k, r;
    logic [7:0] fv;
    goal = ticks_made + n;
    while (ticks_made < goal) begin
      r = $urandom_range(99);
      fv = pick_fire();
      if (r < 70) begin
        k = $urandom_range(1, 3);
        repeat (k)
          add_tick(1'b1, 1'b1, fpkc_pkg::ST_ENABLED, fresh_idx(), fv, rand_byte(), rand_byte(),
                   step_clock());
        add_tick(1'b1, 1'b1, fpkc_pkg::ST_PRIMED, fresh_idx(), fv, rand_byte(), rand_byte(),
                 step_clock());
        add_tick(1'b1, 1'b1, fpkc_pkg::ST_FIRING, fresh_idx(), fv, rand_byte(), rand_byte(),
                 step_clock());
        k = $urandom_range(1, 6);
        repeat (k) begin
          r = $urandom_range(99);
          if (r < 50)
            add_tick(1'b0, rand_bit(), rand_st(), rand_byte(), rand_byte(), rand_byte(),
                     rand_byte(), step_clock());
          else if (r < 80)
            add_tick(1'b1, 1'b1, fpkc_pkg::ST_FIRING, fresh_idx(), pick_fire(), rand_byte(),
                     rand_byte(), step_clock());
          else
            add_tick(1'b1, 1'b1, fpkc_pkg::ST_ADJUSTING, fresh_idx(), pick_fire(), rand_byte(),
                     rand_byte(), step_clock());
        end
      end else if (r < 85) begin
        add_tick(rand_bit(), rand_bit(), rand_st(), rand_byte(), rand_byte(), rand_byte(),
                 rand_byte(), step_clock());
      end else if (r < 93) begin
        add_tick(1'b1, 1'b0, rand_st(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                 step_clock());
      end else begin
        add_tick(1'b1, 1'b1, 3'($urandom_range(5, 7)), fresh_idx(), fv, rand_byte(),
                 rand_byte(), step_clock());
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      fpkc_pkg::REG_KEEPALIVE:  ka_limit = val;
      fpkc_pkg::REG_MIN_PULSE:  base_open = val[9:0];
      fpkc_pkg::REG_PULSE_STEP: open_step = val[6:0];
      fpkc_pkg::REG_MAX_FIRE:   fire_cap = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [15:0] ka, logic [15:0] base, logic [15:0] stp,
                               logic [15:0] cap);
    write_reg(fpkc_pkg::REG_KEEPALIVE, ka);
    write_reg(fpkc_pkg::REG_MIN_PULSE, base);
    write_reg(fpkc_pkg::REG_PULSE_STEP, stp);
    write_reg(fpkc_pkg::REG_MAX_FIRE, cap);
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    phase_sel = 1;
    send_idle_pct = 33;
    recv_idle_pct = 78;
    add_tick(1'b0, 1'b0, fpkc_pkg::ST_DISABLED, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    add_tick(1'b1, 1'b0, fpkc_pkg::ST_ENABLED, 8'd9, 8'd3, 8'h3F, 8'h3F, 32'd50);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_ENABLED, 8'd1, 8'd0, 8'h3F, 8'h7F, 32'd100);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_ENABLED, 8'd2, 8'd0, 8'hBF, 8'h40, 32'd200);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_ENABLED, 8'd3, 8'd0, 8'h00, 8'hFF, 32'd300);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_PRIMED, 8'd4, 8'd20, 8'h15, 8'h2A, 32'd400);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_FIRING, 8'd5, 8'd20, 8'h00, 8'h00, 32'd500);
    add_tick(1'b0, 1'b0, fpkc_pkg::ST_DISABLED, 8'd0, 8'd0, 8'd0, 8'd0, 32'd600);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_FIRING, 8'd6, 8'd20, 8'h00, 8'h00, 32'd700);
    add_tick(1'b0, 1'b0, fpkc_pkg::ST_DISABLED, 8'd0, 8'd0, 8'd0, 8'd0, 32'd800);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_FIRING, 8'd7, 8'd21, 8'h00, 8'h00, 32'd900);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_ENABLED, 8'd8, 8'd255, 8'h01, 8'h41, 32'd1000);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_FIRING, 8'd9, 8'd0, 8'h00, 8'h00, 32'd1100);
    add_tick(1'b1, 1'b1, 3'd5, 8'd10, 8'd0, 8'h00, 8'h00, 32'd1150);
    add_tick(1'b1, 1'b1, 3'd6, 8'd11, 8'd0, 8'h00, 8'h00, 32'd1300);
    add_tick(1'b1, 1'b1, 3'd7, 8'd12, 8'd0, 8'h00, 8'h00, 32'd1400);
    add_tick(1'b0, 1'b0, fpkc_pkg::ST_DISABLED, 8'd0, 8'd0, 8'd0, 8'd0, 32'd2401);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_ENABLED, 8'd12, 8'd0, 8'h20, 8'h60, 32'd2500);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_ENABLED, 8'd13, 8'd0, 8'h20, 8'h60, 32'd2600);
    add_tick(1'b1, 1'b1, fpkc_pkg::ST_FIRING, 8'd14, 8'd20, 8'h00, 8'h00, 32'hFFFF_FF00);
    add_tick(1'b0, 1'b0, fpkc_pkg::ST_DISABLED, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FF64);
    add_tick(1'b1, 1'b0, fpkc_pkg::ST_ENABLED, 8'd15, 8'd0, 8'h00, 8'h00, 32'hFFFF_FFFF);
    add_tick(1'b1, 1'b1, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);
    drain();
    load_settings(16'd500, 16'd50, 16'd5, 16'd30);
    add_random(130);
    drain();

    phase_sel = 2;
    send_idle_pct = 78;
    recv_idle_pct = 33;
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_random(130);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(16'd0, 16'd0, 16'd0, 16'd0);
    phase_sel = 3;
    add_random(130);
    drain();
    load_settings(16'd250, 16'd1000, 16'd100, 16'd20);
    add_random(130);
    drain();

    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("fire_pulse_keepalive_controller test passed");
    end else begin
      $display("fire_pulse_keepalive_controller test failed");
    end
    $finish;
  end

endmodule
